// ===== hw/rtl/lpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpsc_pkg : shared types and constants for the LRU page-slot cache
// Slot count, derived widths, request modes and sequencer states.
// ----------------------------------------------------------------------------
package lpsc_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int KEY_W     = 64;
  localparam int SLOT_W    = 4;

  // s_tdata : key [63:0], slot_in [67:64], zero pad to 72 bits
  localparam int S_DATA_W  = 72;
  // m_tdata : hit [0], slot_out [4:1], status [5], zero pad to 8 bits
  localparam int M_DATA_W  = 8;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_UNPIN  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_RESULT
  } state_t;

endpackage

// ===== hw/rtl/lpsc_ram.sv =====
// ----------------------------------------------------------------------------
// lpsc_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lru_page_slot_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru_page_slot_cache_core : fully associative page-slot directory, LRU + pins
// Maps 64-bit keys to slots; lookup, allocate (with eviction) and unpin.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream carries one request: s_tuser = mode (lookup, allocate,
//   unpin), s_tdata = key and slot_in. Master stream returns one result per
//   request: hit, slot_out, status in m_tdata.
//   One request at a time; s_tready is high only between requests.
//   Lookup and allocate with every slot used walk all NUM_SLOTS slots through
//   one shared key/rank comparator, one slot a cycle, behind the registered
//   read of the key RAM, then the drain and update states lead to the result
//   state. Allocate of a never-used slot skips the scan and goes to update;
//   unpin and unused mode go straight to the result state.
//   Result sits in an output register; if the receiver stalls, the finished
//   request waits in the sequencer until the register frees up.
//   Reset clears valid bits, pins, ranks and the fill count;
//   the key RAM is not cleared, an entry is only compared once it is valid.
// ----------------------------------------------------------------------------
module lru_page_slot_cache_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lpsc_pkg::S_DATA_W-1:0] s_tdata,   // key, slot_in, pad
  input  logic [1:0]                    s_tuser,   // mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lpsc_pkg::M_DATA_W-1:0] m_tdata    // hit, slot_out, status, pad
);

  import lpsc_pkg::*;

  state_t              state, state_next;
  logic [IDX_W-1:0]    cnt;
  logic                e_vld;
  logic [IDX_W-1:0]    e_idx;
  mode_t               req_mode;
  logic [KEY_W-1:0]    req_key;
  logic                sel_vld;
  logic [IDX_W-1:0]    best;
  logic [IDX_W-1:0]    best_rank;
  logic                fresh;
  logic                res_hit;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_status;
  logic                out_hit;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_status;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [NUM_SLOTS-1:0] slot_pinned;
  logic [IDX_W-1:0]    rank [NUM_SLOTS];
  logic [CNT_W-1:0]    slots_used;

  logic                accept;
  logic                ram_we;
  logic [KEY_W-1:0]    rd_key;
  logic                cand;
  logic                full;
  logic                out_free;
  logic                do_update;
  logic [CNT_W-1:0]    used_after;
  mode_t               in_mode;
  logic [KEY_W-1:0]    in_key;
  logic [SLOT_W-1:0]   in_slot;

  assign in_mode  = mode_t'(s_tuser);
  assign in_key   = s_tdata[KEY_W-1:0];
  assign in_slot  = s_tdata[KEY_W+SLOT_W-1:KEY_W];
  assign accept   = s_tvalid && s_tready;
  assign full     = (slots_used == CNT_W'(NUM_SLOTS));
  assign out_free = !m_tvalid || m_tready;
  assign do_update = (state == S_UPDATE) && sel_vld &&
                     ((req_mode == MODE_LOOKUP) || (req_mode == MODE_ALLOC));
  assign used_after = slots_used + CNT_W'(fresh);

  lpsc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NUM_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best),
    .wdata (req_key),
    .raddr (cnt),
    .rdata (rd_key)
  );

  // shared compare unit: one slot per cycle
  always_comb begin
    if (req_mode == MODE_LOOKUP) begin
      cand = slot_valid[e_idx] && (rd_key == req_key) &&
             (!sel_vld || (rank[e_idx] < best_rank));
    end else begin
      cand = !slot_pinned[e_idx] && (!sel_vld || (rank[e_idx] > best_rank));
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_LOOKUP) begin
            state_next = S_SCAN;
          end else if (in_mode == MODE_ALLOC) begin
            state_next = full ? S_SCAN : S_UPDATE;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        if (cnt == IDX_W'(NUM_SLOTS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_UPDATE;
      S_UPDATE: state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    ram_we   = 1'b0;
    unique case (state)
      S_IDLE:   s_tready = 1'b1;
      S_UPDATE: ram_we   = sel_vld && (req_mode == MODE_ALLOC);
      default: begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan counter and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      e_vld <= 1'b0;
    end else begin
      e_vld <= (state == S_SCAN);
      if (state == S_SCAN) begin
        cnt <= cnt + IDX_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_idx <= cnt;
  end

  // request and selection registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_vld <= 1'b0;
      fresh   <= 1'b0;
    end else if (accept) begin
      req_mode <= in_mode;
      req_key  <= in_key;
      fresh    <= (in_mode == MODE_ALLOC) && !full;
      sel_vld  <= (in_mode == MODE_ALLOC) && !full;
      best      <= IDX_W'(slots_used);
      best_rank <= IDX_W'(slots_used);
    end else if (e_vld && cand) begin
      sel_vld   <= 1'b1;
      best      <= e_idx;
      best_rank <= rank[e_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_hit    <= 1'b0;
      res_status <= 1'b0;
      res_slot   <= (in_mode == MODE_UNPIN) ? in_slot : '0;
    end else if (state == S_UPDATE) begin
      res_hit    <= sel_vld && (req_mode == MODE_LOOKUP);
      res_status <= !sel_vld && (req_mode == MODE_ALLOC);
      res_slot   <= sel_vld ? SLOT_W'(best) : '0;
    end
  end

  // directory state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      slot_pinned <= '0;
      slots_used  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (accept && (in_mode == MODE_UNPIN) && (32'(in_slot) < NUM_SLOTS)) begin
        slot_pinned[IDX_W'(in_slot)] <= 1'b0;
      end
      if (do_update) begin
        // move to front: every used slot more recent than the chosen one ages
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (IDX_W'(i) == best) begin
            rank[i] <= '0;
          end else if ((CNT_W'(i) < used_after) && (rank[i] < best_rank)) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
        if (req_mode == MODE_ALLOC) begin
          slot_valid[best]  <= 1'b1;
          slot_pinned[best] <= 1'b1;
          slots_used        <= used_after;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_RESULT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      out_hit    <= res_hit;
      out_slot   <= res_slot;
      out_status <= res_status;
    end
  end

  assign m_tdata = {(M_DATA_W - SLOT_W - 2)'(0), out_status, out_slot, out_hit};

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request taken while previous one in flight");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == 32'(slots_used))
    else $error("valid slots disagree with fill count");

  a_err_all_pinned: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) && res_status |-> (&slot_pinned) && full)
    else $error("allocate error with an unpinned slot present");

  a_hit_is_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) && sel_vld && (req_mode == MODE_LOOKUP) |-> slot_valid[best])
    else $error("lookup hit on an invalid slot");
`endif

endmodule
